FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: src/mdhc_pkg.sv
// ----------------------------------------------------------------------------
// mdhc_pkg
// Constants shared by the MPPT duty hill climber and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package mdhc_pkg;

  localparam int DUTY_W    = 8;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIM_TOP  = 2'd2;

  // Register reset values.
  localparam logic [7:0] GAIN_RST      = 8'd1;
  localparam logic [7:0] DECIM_TOP_RST = 8'd120;

  // Duty and step limits.
  localparam logic [DUTY_W-1:0] DUTY_INIT = 8'd10;
  localparam logic [DUTY_W-1:0] DUTY_MIN  = 8'd1;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 8'd140;
  localparam logic [STEP_W-1:0] STEP_MIN  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MAX  = 4'd15;
  localparam logic [STEP_W-1:0] STEP_INIT = 4'd5;

endpackage

`default_nettype wire

FILE: src/mdhc_sample_if.sv
// ----------------------------------------------------------------------------
// mdhc_sample_if
// Valid/ready channel carrying one panel voltage sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdhc_sample_if #(
  parameter int SAMPLE_BITS = 8
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] panel_volt;

  modport source (output valid, output panel_volt, input ready);
  modport sink   (input valid, input panel_volt, output ready);
endinterface

`default_nettype wire

FILE: src/mdhc_result_if.sv
// ----------------------------------------------------------------------------
// mdhc_result_if
// Valid/ready channel carrying the duty result of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdhc_result_if
  import mdhc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_out;
  logic              duty_updated;
  logic              pwm_invert;

  modport source (output valid, output duty_out, output duty_updated,
                  output pwm_invert, input ready);
  modport sink   (input valid, input duty_out, input duty_updated,
                  input pwm_invert, output ready);
endinterface

`default_nettype wire

FILE: src/mdhc_cfg_if.sv
// ----------------------------------------------------------------------------
// mdhc_cfg_if
// Register write channel: one register index and its data per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdhc_cfg_if
  import mdhc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/mppt_duty_hill_climber_core.sv
// ----------------------------------------------------------------------------
// mppt_duty_hill_climber_core
// Variable-step perturb-and-observe MPPT duty controller with a shared
// shift-and-subtract divider for the step size.
// ----------------------------------------------------------------------------
// Usage. Panel voltage samples arrive on the samp channel, one per
// transaction, and every sample produces exactly one transaction on the res
// channel carrying the current duty, an update flag and the PWM polarity.
// Registers (step gain, output inversion, decimation top) are written on the
// cfg channel, which is always ready; write it only while the block is idle.
// A sample that does not hit the decimation top only advances the counter; its
// result is then passed to the output register. A sample that hits the top
// runs the controller: a difference state forms the voltage and duty
// differences, a multiply state multiplies the gain by the voltage change, the
// shared subtractor then runs one saturation check plus at most four restoring
// quotient steps (all skipped when the duty did not change), an apply state
// applies and clamps the step, and a done state loads the output register.
// The samp channel is ready only when no sample is in flight, so one sample
// is processed at a time. A finished result waits in the output register while
// the receiver stalls, and the next sample may be accepted meanwhile; its own
// result waits in the sequencer until the output register frees up.
// Reset (synchronous, active high) restores the register defaults, clears the
// sample counter and last voltage, and sets both duty values to 10.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mppt_duty_hill_climber_core
  import mdhc_pkg::*;
#(
  parameter int SAMPLE_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  mdhc_sample_if.sink    samp,
  mdhc_result_if.source  res,
  mdhc_cfg_if.sink       cfg
);

  // Gain times voltage magnitude; wide enough to also hold the divisor
  // shifted left by four for the saturation check.
  localparam int NUM_W = 8 + SAMPLE_BITS;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIFF  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Configuration registers.
  logic [7:0] step_gain;
  logic       invert_output;
  logic [7:0] decimation_top;

  // Controller state.
  logic [7:0]             sample_count;
  logic [SAMPLE_BITS-1:0] last_voltage;
  logic [DUTY_W-1:0]      duty_now;
  logic [DUTY_W-1:0]      duty_prev;

  // Per-item working registers.
  logic [2:0]             state;
  logic [SAMPLE_BITS-1:0] volt;
  logic                   upd;
  logic [SAMPLE_BITS-1:0] mag_v;
  logic [DUTY_W-1:0]      mag_d;
  logic                   dv_neg;
  logic                   dd_neg;
  logic [NUM_W-1:0]       rem;
  logic [2:0]             sh;
  logic [STEP_W-1:0]      quot;
  logic                   sat;

  // Output register.
  logic              out_valid;
  logic [DUTY_W-1:0] out_duty;
  logic              out_upd;
  logic              out_inv;

  assign samp.ready       = (state == S_IDLE);
  assign cfg.ready        = 1'b1;
  assign res.valid        = out_valid;
  assign res.duty_out     = out_duty;
  assign res.duty_updated = out_upd;
  assign res.pwm_invert   = out_inv;

  logic in_fire;
  logic hit;
  logic load_out;
  assign in_fire  = samp.valid && samp.ready;
  assign hit      = (sample_count == decimation_top);
  // A finished result moves into the output register once that register is
  // empty or is being emptied in the same cycle.
  assign load_out = (state == S_DONE) && (!out_valid || res.ready);

  // Difference stage: signed differences and their magnitudes.
  logic [SAMPLE_BITS:0] dv_diff;
  logic [SAMPLE_BITS:0] dv_negated;
  logic [DUTY_W:0]      dd_diff;
  logic [DUTY_W:0]      dd_negated;
  assign dv_diff    = {1'b0, volt} - {1'b0, last_voltage};
  assign dv_negated = -dv_diff;
  assign dd_diff    = {1'b0, duty_now} - {1'b0, duty_prev};
  assign dd_negated = -dd_diff;

  // The shared subtract-and-compare unit of the divider. It compares the
  // partial remainder against the duty magnitude shifted by the current
  // quotient bit position; position four is the saturation check.
  logic [NUM_W-1:0] divisor_sh;
  logic [NUM_W:0]   trial;
  logic             trial_ge;
  assign divisor_sh = NUM_W'(mag_d) << sh;
  assign trial      = {1'b0, rem} - {1'b0, divisor_sh};
  assign trial_ge   = !trial[NUM_W];

  // Step selection and duty update.
  logic              dv_pos;
  logic              dd_pos;
  logic              rise;
  logic [STEP_W-1:0] step;
  logic [DUTY_W:0]   duty_up;
  logic [DUTY_W:0]   duty_dn;
  logic [DUTY_W-1:0] duty_new;

  always_comb begin
    dv_pos = !dv_neg && (mag_v != '0);
    dd_pos = !dd_neg && (mag_d != '0);
    if (mag_d == '0) begin
      // No duty change: full step on any voltage change, else a small decrease.
      step = (mag_v != '0) ? STEP_MAX : STEP_MIN;
      rise = dv_pos;
    end else begin
      if (sat) begin
        step = STEP_MAX;
      end else if (quot == '0) begin
        step = STEP_MIN;
      end else begin
        step = quot;
      end
      rise = (dv_pos && dd_pos) || (dv_neg && dd_neg);
    end
    if (duty_now == DUTY_INIT && duty_prev == DUTY_INIT) begin
      step = STEP_INIT;
    end
    duty_up = {1'b0, duty_now} + (DUTY_W + 1)'(step);
    duty_dn = {1'b0, duty_now} - (DUTY_W + 1)'(step);
    if (rise) begin
      duty_new = (duty_up > {1'b0, DUTY_MAX}) ? DUTY_MAX : duty_up[DUTY_W-1:0];
    end else begin
      duty_new = (duty_dn[DUTY_W] || duty_dn == '0) ? DUTY_MIN : duty_dn[DUTY_W-1:0];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_gain      <= GAIN_RST;
      invert_output  <= 1'b0;
      decimation_top <= DECIM_TOP_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_STEP_GAIN: step_gain      <= cfg.data;
        REG_INVERT:    invert_output  <= cfg.data[0];
        REG_DECIM_TOP: decimation_top <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // Output register: takes a finished result and holds it until the
  // receiver accepts the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      out_duty  <= duty_now;
      out_upd   <= upd;
      out_inv   <= invert_output;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_count <= '0;
      last_voltage <= '0;
      duty_now     <= DUTY_INIT;
      duty_prev    <= DUTY_INIT;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            volt <= samp.panel_volt;
            upd  <= hit;
            if (hit) begin
              sample_count <= '0;
              state        <= S_DIFF;
            end else begin
              sample_count <= sample_count + 8'd1;
              state        <= S_DONE;
            end
          end
        end
        S_DIFF: begin
          dv_neg <= dv_diff[SAMPLE_BITS];
          mag_v  <= dv_diff[SAMPLE_BITS] ? dv_negated[SAMPLE_BITS-1:0]
                                         : dv_diff[SAMPLE_BITS-1:0];
          dd_neg <= dd_diff[DUTY_W];
          mag_d  <= dd_diff[DUTY_W] ? dd_negated[DUTY_W-1:0] : dd_diff[DUTY_W-1:0];
          state  <= S_MUL;
        end
        S_MUL: begin
          rem   <= NUM_W'(step_gain) * NUM_W'(mag_v);
          sh    <= 3'd4;
          quot  <= '0;
          sat   <= 1'b0;
          state <= (mag_d == '0) ? S_APPLY : S_DIV;
        end
        S_DIV: begin
          if (sh == 3'd4) begin
            // Quotient of sixteen or more saturates the step.
            if (trial_ge) begin
              sat   <= 1'b1;
              state <= S_APPLY;
            end else begin
              sh <= 3'd3;
            end
          end else begin
            if (trial_ge) begin
              rem <= trial[NUM_W-1:0];
            end
            quot[sh[1:0]] <= trial_ge;
            if (sh == 3'd0) begin
              state <= S_APPLY;
            end else begin
              sh <= sh - 3'd1;
            end
          end
        end
        S_APPLY: begin
          last_voltage <= volt;
          duty_prev    <= duty_now;
          duty_now     <= duty_new;
          state        <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The duty register never leaves its clamp range.
  `ASSERT_ALWAYS(a_duty_range, clk, rst, duty_now >= DUTY_MIN && duty_now <= DUTY_MAX)
  // A sample that misses the decimation top goes straight to the result stage.
  `ASSERT_NEXT(a_skip_direct, clk, rst, in_fire && !hit, state == S_DONE)
  // Without saturation, the divider leaves a remainder below the divisor.
  `ASSERT_IMPLIES(a_rem_below, clk, rst, state == S_APPLY && mag_d != '0 && !sat, rem < NUM_W'(mag_d))

endmodule

`default_nettype wire
